// ===== hw/rtl/psrw_pkg.sv =====
// ----------------------------------------------------------------------------
// psrw_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package psrw_pkg;

   localparam int TABLE_SLOTS  = 32;
   localparam int WINDOW_WORDS = 256;
   localparam int WIN_BITS     = WINDOW_WORDS * 64;

   localparam int SLOT_W  = $clog2(TABLE_SLOTS);
   localparam int WORD_W  = (WINDOW_WORDS > 1) ? $clog2(WINDOW_WORDS) : 1;
   localparam int POS_W   = $clog2(WIN_BITS);
   localparam int RNG_W   = POS_W + 1;
   localparam int ADDR_W  = $clog2(TABLE_SLOTS * WINDOW_WORDS);
   localparam int DIV_MAX = (TABLE_SLOTS > WIN_BITS) ? TABLE_SLOTS : WIN_BITS;
   localparam int DIV_W   = $clog2(DIV_MAX) + 1;

   localparam logic [63:0] HASH_MULT  = 64'h9e3779b185ebca87;
   localparam int          HASH_SHIFT = 33;
   localparam logic [31:0] IDLE_RESET = 32'd60000;

   typedef enum logic [1:0] {
      ST_EMPTY = 2'd0,
      ST_USED  = 2'd1,
      ST_TOMB  = 2'd2
   } slot_status_type;

   typedef enum logic [2:0] {
      V_NEW     = 3'd0,
      V_ADV     = 3'd1,
      V_FRESH   = 3'd2,
      V_REPLAY  = 3'd3,
      V_OLD     = 3'd4,
      V_FULL    = 3'd5,
      V_UNKNOWN = 3'd6
   } verdict_type;

   typedef enum logic {
      MOD_HOME = 1'b0,
      MOD_CNT  = 1'b1
   } mod_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        hash_step;
      logic        mod_start;
      mod_sel_type mod_sel;
      logic        probe_init;
      logic        latch_cpos;
      logic        probe_step;
      logic        slot_new;
      logic        slot_adv;
      logic        slot_touch;
      logic        sweep_init;
      logic        sweep_step;
      logic        rng_init;
      logic        rng_rd;
      logic        rng_wr;
      logic        cnt_rd;
      logic        set_wr;
      logic        set_res;
      logic        res_accept;
      verdict_type res_verdict;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic hash_done;
      logic mod_busy;
      logic probe_end;
      logic found;
      logic hit;
      logic commit;
      logic greater;
      logic too_old;
      logic big_step;
      logic bit_set;
      logic sweep_last;
      logic rng_last;
      logic out_free;
   } stat_type;

endpackage

// ===== hw/rtl/psrw_modred.sv =====
// ----------------------------------------------------------------------------
// psrw_modred
// Remainder by a power-of-two constant, taken from the low bits by a mask.
// ----------------------------------------------------------------------------
module psrw_modred (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [psrw_pkg::DIV_W-1:0] value,
   input  logic [psrw_pkg::DIV_W-1:0] divisor,
   output logic                       busy,
   output logic [psrw_pkg::DIV_W-1:0] remainder
);
   import psrw_pkg::*;

   logic [DIV_W-1:0] low_ff;
   logic [DIV_W-1:0] div_ff;
   logic [DIV_W-1:0] rem_ff;
   logic             busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         low_ff <= value;
         div_ff <= divisor;
      end
      if (busy_ff) begin
         rem_ff <= low_ff & (div_ff - 1'b1);
      end
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/psrw_ctrl.sv =====
// ----------------------------------------------------------------------------
// psrw_ctrl
// Sequencer that steps one transaction through hash, probe and window update.
// ----------------------------------------------------------------------------
module psrw_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  psrw_pkg::stat_type stat,
   output psrw_pkg::cmd_type  cmd
);
   import psrw_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_HASH   = 13'b0000000000010,
      S_HMOD   = 13'b0000000000100,
      S_CMOD   = 13'b0000000001000,
      S_PROBE  = 13'b0000000010000,
      S_EVAL   = 13'b0000000100000,
      S_TEST   = 13'b0000001000000,
      S_CLRALL = 13'b0000010000000,
      S_CLRRD  = 13'b0000100000000,
      S_CLRWR  = 13'b0001000000000,
      S_SETRD  = 13'b0010000000000,
      S_SETWR  = 13'b0100000000000,
      S_DONE   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_HASH;
            end
         end
         S_HASH: begin
            if (stat.hash_done) begin
               cmd.mod_start = 1'b1;
               cmd.mod_sel   = MOD_HOME;
               state_in      = S_HMOD;
            end else begin
               cmd.hash_step = 1'b1;
            end
         end
         S_HMOD: begin
            if (!stat.mod_busy) begin
               cmd.probe_init = 1'b1;
               cmd.mod_start  = 1'b1;
               cmd.mod_sel    = MOD_CNT;
               state_in       = S_CMOD;
            end
         end
         S_CMOD: begin
            if (!stat.mod_busy) begin
               cmd.latch_cpos = 1'b1;
               state_in       = S_PROBE;
            end
         end
         S_PROBE: begin
            cmd.probe_step = 1'b1;
            if (stat.probe_end) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.set_res = 1'b1;
            state_in    = S_DONE;
            if (!stat.commit) begin
               if (!stat.hit) begin
                  cmd.res_accept  = 1'b1;
                  cmd.res_verdict = V_UNKNOWN;
               end else if (stat.greater) begin
                  cmd.res_accept  = 1'b1;
                  cmd.res_verdict = V_ADV;
               end else if (stat.too_old) begin
                  cmd.res_verdict = V_OLD;
               end else begin
                  cmd.set_res = 1'b0;
                  cmd.cnt_rd  = 1'b1;
                  state_in    = S_TEST;
               end
            end else if (!stat.found) begin
               cmd.res_verdict = V_FULL;
            end else if (!stat.hit) begin
               cmd.res_accept  = 1'b1;
               cmd.res_verdict = V_NEW;
               cmd.slot_new    = 1'b1;
               cmd.sweep_init  = 1'b1;
               state_in        = S_CLRALL;
            end else if (stat.greater) begin
               cmd.res_accept  = 1'b1;
               cmd.res_verdict = V_ADV;
               cmd.slot_adv    = 1'b1;
               if (stat.big_step) begin
                  cmd.sweep_init = 1'b1;
                  state_in       = S_CLRALL;
               end else begin
                  cmd.rng_init = 1'b1;
                  state_in     = S_CLRRD;
               end
            end else if (stat.too_old) begin
               cmd.res_verdict = V_OLD;
            end else begin
               cmd.set_res = 1'b0;
               cmd.cnt_rd  = 1'b1;
               state_in    = S_TEST;
            end
         end
         S_TEST: begin
            cmd.set_res = 1'b1;
            state_in    = S_DONE;
            if (stat.bit_set) begin
               cmd.res_verdict = V_REPLAY;
            end else begin
               cmd.res_accept  = 1'b1;
               cmd.res_verdict = V_FRESH;
               if (stat.commit) begin
                  cmd.set_wr     = 1'b1;
                  cmd.slot_touch = 1'b1;
               end
            end
         end
         S_CLRALL: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_SETRD;
            end
         end
         S_CLRRD: begin
            cmd.rng_rd = 1'b1;
            state_in   = S_CLRWR;
         end
         S_CLRWR: begin
            cmd.rng_wr = 1'b1;
            state_in   = stat.rng_last ? S_SETRD : S_CLRRD;
         end
         S_SETRD: begin
            cmd.cnt_rd = 1'b1;
            state_in   = S_SETWR;
         end
         S_SETWR: begin
            cmd.set_wr = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

// ===== hw/rtl/psrw_datapath.sv =====
// ----------------------------------------------------------------------------
// psrw_datapath
// Session table, window memory, hash and compare logic, and result register.
// ----------------------------------------------------------------------------
module psrw_datapath (
   input  logic               clock,
   input  logic               reset,
   input  psrw_pkg::cmd_type  cmd,
   output psrw_pkg::stat_type stat,
   input  logic               req_tuser,
   input  logic [191:0]       req_tdata,
   input  logic               csr_we,
   input  logic [31:0]        csr_wdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata
);
   import psrw_pkg::*;

   logic [31:0] idle_ff;
   logic        commit_ff;
   logic [63:0] sid_ff, cnt_ff, now_ff;
   logic [63:0] acc_ff;
   logic [1:0]  hcnt_ff;

   slot_status_type  status_ff [TABLE_SLOTS];
   logic [63:0]      session_ff [TABLE_SLOTS];
   logic [63:0]      highest_ff [TABLE_SLOTS];
   logic [POS_W-1:0] hpos_ff [TABLE_SLOTS];
   logic [63:0]      lastuse_ff [TABLE_SLOTS];

   logic [SLOT_W-1:0] idx_ff, tomb_ff, slot_ff, pcnt_ff;
   logic              tomb_v_ff, found_ff, hit_ff;
   logic [63:0]       hi_ff;
   logic [POS_W-1:0]  hpos_w_ff, cpos_ff, p_ff;
   logic [RNG_W-1:0]  rem_ff;
   logic [WORD_W-1:0] sw_ff;

   logic [63:0] win_mem [TABLE_SLOTS * WINDOW_WORDS];
   logic [63:0] rdata_ff;

   logic        res_acc_ff, rsp_valid_ff, rsp_acc_ff;
   verdict_type res_ver_ff, rsp_ver_ff;

   // Hash multiply, one 32x32 partial product per step.
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod, hashed;
   always_comb begin
      case (hcnt_ff)
         2'd0: begin
            mul_a = sid_ff[31:0];
            mul_b = HASH_MULT[31:0];
         end
         2'd1: begin
            mul_a = sid_ff[31:0];
            mul_b = HASH_MULT[63:32];
         end
         default: begin
            mul_a = sid_ff[63:32];
            mul_b = HASH_MULT[31:0];
         end
      endcase
   end
   assign prod   = {32'd0, mul_a} * {32'd0, mul_b};
   assign hashed = acc_ff ^ (acc_ff >> HASH_SHIFT);

   logic             mod_busy;
   logic [DIV_W-1:0] mod_rem;
   psrw_modred u_modred (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .value     ((cmd.mod_sel == MOD_CNT) ? cnt_ff[DIV_W-1:0] : hashed[DIV_W-1:0]),
      .divisor   ((cmd.mod_sel == MOD_CNT) ? DIV_W'(WIN_BITS) : DIV_W'(TABLE_SLOTS)),
      .busy      (mod_busy),
      .remainder (mod_rem)
   );

   // Probe of the current slot.
   slot_status_type   cur_st;
   logic [63:0]       cur_lu, age;
   logic              cur_empty, cur_used, cur_stale, cur_match, cur_free, probe_last;
   logic [SLOT_W-1:0] idx_next;
   always_comb begin
      cur_st     = status_ff[idx_ff];
      cur_lu     = lastuse_ff[idx_ff];
      age        = now_ff - cur_lu;
      cur_empty  = (cur_st == ST_EMPTY);
      cur_used   = (cur_st == ST_USED);
      cur_stale  = cur_used && (now_ff > cur_lu) && (age > {32'd0, idle_ff});
      cur_match  = cur_used && !cur_stale && (session_ff[idx_ff] == sid_ff);
      cur_free   = (cur_st == ST_TOMB) || cur_stale;
      probe_last = (pcnt_ff == SLOT_W'(TABLE_SLOTS - 1));
      idx_next   = (idx_ff == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : idx_ff + 1'b1;
   end

   // Window addressing and masks.
   logic [ADDR_W-1:0] base, cnt_addr, rng_addr, sw_addr, raddr, waddr;
   logic [63:0]       bit_mask, rng_mask, wdata;
   logic [5:0]        rb, re;
   logic [6:0]        avail, nbits;
   logic [63:0]       fwd, bwd;
   logic              we;
   always_comb begin
      base     = ADDR_W'(slot_ff) * ADDR_W'(WINDOW_WORDS);
      cnt_addr = base + ADDR_W'(WORD_W'(cpos_ff >> 6));
      rng_addr = base + ADDR_W'(WORD_W'(p_ff >> 6));
      sw_addr  = base + ADDR_W'(sw_ff);
      bit_mask = 64'd1 << cnt_ff[5:0];
      rb       = p_ff[5:0];
      avail    = 7'd64 - {1'b0, rb};
      nbits    = (rem_ff < RNG_W'(avail)) ? 7'(rem_ff) : avail;
      re       = 6'({1'b0, rb} + nbits - 7'd1);
      fwd      = {64{1'b1}} << rb;
      bwd      = {64{1'b1}} >> (6'd63 - re);
      rng_mask = fwd & bwd;
      raddr    = cmd.rng_rd ? rng_addr : cnt_addr;
      we       = cmd.sweep_step || cmd.rng_wr || cmd.set_wr;
      if (cmd.sweep_step) begin
         waddr = sw_addr;
         wdata = 64'd0;
      end else if (cmd.rng_wr) begin
         waddr = rng_addr;
         wdata = rdata_ff & ~rng_mask;
      end else begin
         waddr = cnt_addr;
         wdata = rdata_ff | bit_mask;
      end
   end

   logic [POS_W-1:0] p_step;
   assign p_step = p_ff + POS_W'(nbits);

   always_ff @(posedge clock) begin
      if (we) begin
         win_mem[waddr] <= wdata;
      end
      if (cmd.rng_rd || cmd.cnt_rd) begin
         rdata_ff <= win_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff <= IDLE_RESET;
      end else if (csr_we) begin
         idle_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         commit_ff <= req_tuser;
         sid_ff    <= req_tdata[63:0];
         cnt_ff    <= req_tdata[127:64];
         now_ff    <= req_tdata[191:128];
      end
      if (cmd.load_req) begin
         hcnt_ff <= 2'd0;
      end else if (cmd.hash_step) begin
         hcnt_ff <= hcnt_ff + 2'd1;
         acc_ff  <= (hcnt_ff == 2'd0) ? prod : acc_ff + {prod[31:0], 32'd0};
      end
      if (cmd.latch_cpos) begin
         cpos_ff <= mod_rem[POS_W-1:0];
      end
      if (cmd.probe_init) begin
         idx_ff    <= mod_rem[SLOT_W-1:0];
         pcnt_ff   <= '0;
         tomb_v_ff <= 1'b0;
         found_ff  <= 1'b0;
         hit_ff    <= 1'b0;
      end else if (cmd.probe_step) begin
         idx_ff  <= idx_next;
         pcnt_ff <= pcnt_ff + 1'b1;
         if (cur_free && !tomb_v_ff) begin
            tomb_v_ff <= 1'b1;
            tomb_ff   <= idx_ff;
         end
         if (cur_empty) begin
            found_ff <= 1'b1;
            slot_ff  <= tomb_v_ff ? tomb_ff : idx_ff;
         end else if (cur_match) begin
            found_ff  <= 1'b1;
            hit_ff    <= 1'b1;
            slot_ff   <= idx_ff;
            hi_ff     <= highest_ff[idx_ff];
            hpos_w_ff <= hpos_ff[idx_ff];
         end else if (probe_last) begin
            found_ff <= tomb_v_ff || cur_free;
            slot_ff  <= tomb_v_ff ? tomb_ff : idx_ff;
         end
      end
      if (cmd.sweep_init) begin
         sw_ff <= '0;
      end else if (cmd.sweep_step) begin
         sw_ff <= sw_ff + 1'b1;
      end
      if (cmd.rng_init) begin
         p_ff   <= (hpos_w_ff == POS_W'(WIN_BITS - 1)) ? '0 : hpos_w_ff + 1'b1;
         rem_ff <= RNG_W'(cnt_ff - hi_ff);
      end else if (cmd.rng_wr) begin
         p_ff   <= (p_step == '0) ? '0 : p_step;
         rem_ff <= rem_ff - RNG_W'(nbits);
      end
      if (cmd.set_res) begin
         res_acc_ff <= cmd.res_accept;
         res_ver_ff <= cmd.res_verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            status_ff[i] <= ST_EMPTY;
         end
      end else if (cmd.probe_step && cur_stale) begin
         status_ff[idx_ff] <= ST_TOMB;
      end else if (cmd.slot_new) begin
         status_ff[slot_ff] <= ST_USED;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.slot_new) begin
         session_ff[slot_ff] <= sid_ff;
      end
      if (cmd.slot_new || cmd.slot_adv) begin
         highest_ff[slot_ff] <= cnt_ff;
         hpos_ff[slot_ff]    <= cpos_ff;
      end
      if (cmd.slot_new || cmd.slot_adv || cmd.slot_touch) begin
         lastuse_ff[slot_ff] <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_acc_ff <= res_acc_ff;
         rsp_ver_ff <= res_ver_ff;
      end
   end

   logic [63:0] back, fwd_step;
   assign back     = hi_ff - cnt_ff;
   assign fwd_step = cnt_ff - hi_ff;

   always_comb begin
      stat            = '0;
      stat.hash_done  = (hcnt_ff == 2'd3);
      stat.mod_busy   = mod_busy;
      stat.probe_end  = cur_empty || cur_match || probe_last;
      stat.found      = found_ff;
      stat.hit        = hit_ff;
      stat.commit     = commit_ff;
      stat.greater    = cnt_ff > hi_ff;
      stat.too_old    = back >= 64'(WIN_BITS);
      stat.big_step   = fwd_step >= 64'(WIN_BITS);
      stat.bit_set    = |(rdata_ff & bit_mask);
      stat.sweep_last = (sw_ff == WORD_W'(WINDOW_WORDS - 1));
      stat.rng_last   = (rem_ff == RNG_W'(nbits));
      stat.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ver_ff, rsp_acc_ff};

endmodule

// ===== hw/rtl/per_session_replay_window.sv =====
// ----------------------------------------------------------------------------
// per_session_replay_window
// Per-session sliding-window anti-replay check over a hashed session table.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  req      in         tuser: cmd; tdata: session_id, counter, now
//  rsp      out        tdata: accept, verdict
//  csr      in         wdata: idle_limit
//
// One transaction is handled at a time: it is accepted, hashed, reduced to a home
// slot and a window bit position, probed slot by slot, given a verdict and then
// loaded into the result register once that is free. A new session or a full
// window advance also clears every window word; a shorter advance reads and
// clears each window word it touches. The result register lets the next request in
// while a result waits. Reset marks every slot empty.
// ----------------------------------------------------------------------------
module per_session_replay_window (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,  // session_id, counter, now
   input  logic         req_tuser,  // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,  // accept, verdict[2:0], zero pad
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata
);
   import psrw_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   psrw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   psrw_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== hw/rtl/psrw_checker.sv =====
// ----------------------------------------------------------------------------
// psrw_checker
// Port-level checks on result codes, pacing and output hold.
// ----------------------------------------------------------------------------
module psrw_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   import psrw_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Result changed while stalled.");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:1] != 3'd7 && rsp_tdata[7:4] == 4'd0)
      else $error("Result carries an undefined verdict.");

   a_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[0] == (rsp_tdata[3:1] == V_NEW ||
         rsp_tdata[3:1] == V_ADV || rsp_tdata[3:1] == V_FRESH ||
         rsp_tdata[3:1] == V_UNKNOWN))
      else $error("Accept flag disagrees with verdict.");

   a_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Second request taken while one is in progress.");

endmodule

bind per_session_replay_window psrw_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-session replay window. A directed table
// covers unknown, new, advance, in-window, replay, too-old and big-step cases;
// random traffic over a session pool then fills the table, ages slots out and
// replays counters under several idle limits, with random stalls on both ends.
// Every response is compared against an in-bench model of the session table.
// ----------------------------------------------------------------------------
module tb;
   import psrw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL = 48;

   typedef struct {
      logic        commit;
      logic [63:0] sid;
      logic [63:0] cnt;
      logic [63:0] now;
      bit          typed;
      logic        acc;
      verdict_type ver;
   } row_type;

   typedef struct {
      logic        acc;
      verdict_type ver;
   } verdict_rec_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [191:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [7:0]   rsp_tdata;
   logic         csr_we;
   logic [31:0]  csr_wdata;

   per_session_replay_window DUT (.*);

   // Model state of the session table.
   logic [31:0]     m_idle;
   slot_status_type m_status [TABLE_SLOTS];
   logic [63:0]     m_sid    [TABLE_SLOTS];
   logic [63:0]     m_high   [TABLE_SLOTS];
   logic [63:0]     m_last   [TABLE_SLOTS];
   logic [63:0]     m_win    [TABLE_SLOTS*WINDOW_WORDS];

   verdict_rec_type verdicts_due[$];
   int  errors = 0;
   int  n_sent = 0;
   int  n_seen = 0;
   bit  calm = 0;
   int  vcount[8];

   logic [63:0] pool_sid [POOL];
   logic [63:0] pool_hi  [POOL];
   logic [63:0] clk_now;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30ms;
      $display("tb: FAIL");
      $finish;
   end

   function automatic int win_addr(int s, logic [63:0] c);
      return s * WINDOW_WORDS + int'((c % WIN_BITS) / 64);
   endfunction

   function automatic logic win_get(int s, logic [63:0] c);
      return m_win[win_addr(s, c)][c[5:0]];
   endfunction

   function automatic void win_put(int s, logic [63:0] c, logic v);
      m_win[win_addr(s, c)][c[5:0]] = v;
   endfunction

   function automatic int home_of(logic [63:0] sid);
      logic [63:0] x;
      x = sid * HASH_MULT;
      x = x ^ (x >> HASH_SHIFT);
      return int'(x % TABLE_SLOTS);
   endfunction

   // Probe and update the model; returns the expected verdict.
   function automatic verdict_rec_type predict_verdict(logic commit, logic [63:0] sid,
                                                       logic [63:0] cnt, logic [63:0] now);
      verdict_rec_type r;
      int idx, tomb, s, n;
      bit hit;
      logic [63:0] c, step;
      idx = home_of(sid);
      tomb = -1;
      s = -1;
      hit = 0;
      for (n = 0; n < TABLE_SLOTS; n++) begin
         if (m_status[idx] == ST_EMPTY) begin
            s = (tomb >= 0) ? tomb : idx;
            break;
         end
         if (m_status[idx] == ST_USED && now > m_last[idx] && now - m_last[idx] > m_idle)
            m_status[idx] = ST_TOMB;
         if (m_status[idx] != ST_USED) begin
            if (tomb < 0) tomb = idx;
         end else if (m_sid[idx] == sid) begin
            hit = 1;
            s = idx;
            break;
         end
         idx = (idx + 1) % TABLE_SLOTS;
      end
      if (n == TABLE_SLOTS) s = tomb;
      r.acc = 0;
      if (!commit) begin
         if (s < 0 || !hit) begin r.acc = 1; r.ver = V_UNKNOWN; end
         else if (cnt > m_high[s]) begin r.acc = 1; r.ver = V_ADV; end
         else if (m_high[s] - cnt >= WIN_BITS) r.ver = V_OLD;
         else if (win_get(s, cnt)) r.ver = V_REPLAY;
         else begin r.acc = 1; r.ver = V_FRESH; end
      end else if (s < 0) begin
         r.ver = V_FULL;
      end else if (!hit) begin
         m_status[s] = ST_USED;
         m_sid[s] = sid;
         m_high[s] = cnt;
         m_last[s] = now;
         for (n = 0; n < WINDOW_WORDS; n++) m_win[s*WINDOW_WORDS + n] = '0;
         win_put(s, cnt, 1);
         r.acc = 1; r.ver = V_NEW;
      end else if (cnt > m_high[s]) begin
         step = cnt - m_high[s];
         if (step >= WIN_BITS) begin
            for (n = 0; n < WINDOW_WORDS; n++) m_win[s*WINDOW_WORDS + n] = '0;
         end else begin
            c = m_high[s];
            for (n = 0; n < int'(step); n++) begin
               c = c + 1;
               win_put(s, c, 0);
            end
         end
         m_high[s] = cnt;
         m_last[s] = now;
         win_put(s, cnt, 1);
         r.acc = 1; r.ver = V_ADV;
      end else if (m_high[s] - cnt >= WIN_BITS) begin
         r.ver = V_OLD;
      end else if (win_get(s, cnt)) begin
         r.ver = V_REPLAY;
      end else begin
         m_last[s] = now;
         win_put(s, cnt, 1);
         r.acc = 1; r.ver = V_FRESH;
      end
      return r;
   endfunction

   task automatic send_item(logic commit, logic [63:0] sid, logic [63:0] cnt,
                            logic [63:0] now, bit typed, verdict_rec_type typed_exp);
      verdict_rec_type r;
      if (!calm && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= commit;
      req_tdata  <= {now, cnt, sid};
      do @(posedge clock); while (!req_tready);
      r = predict_verdict(commit, sid, cnt, now);
      if (typed && (r.acc !== typed_exp.acc || r.ver !== typed_exp.ver)) begin
         $error("table row disagrees with model: acc %0d/%0d verdict %0d/%0d",
                typed_exp.acc, r.acc, typed_exp.ver, r.ver);
         errors++;
      end
      verdicts_due.push_back(typed ? typed_exp : r);
      n_sent++;
   endtask

   task automatic drain_and_write(logic [31:0] value);
      req_tvalid <= 0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_we    <= 1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 0;
      m_idle = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         rsp_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 15);
      end
   end

   always @(posedge clock) begin
      verdict_rec_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_seen++;
         if (verdicts_due.size() == 0) begin
            $error("response with no pending transaction: %h", rsp_tdata);
            errors++;
         end else begin
            e = verdicts_due.pop_front();
            vcount[e.ver]++;
            if (rsp_tdata[0] !== e.acc) begin
               $error("accept mismatch: expected %0d actual %0d", e.acc, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[3:1] !== e.ver) begin
               $error("verdict mismatch: expected %0d actual %0d", e.ver, rsp_tdata[3:1]);
               errors++;
            end
         end
      end
   end

   initial begin
      row_type rows[$];
      verdict_rec_type te;
      logic [63:0] ones, cnt, sid;
      logic commit;
      int i, k, ph, r, t;
      logic [31:0] limits[4];

      ones = '1;
      limits = '{32'hFFFF_FFFF, 32'd0, 32'd500, IDLE_RESET};
      reset = 1;
      req_tvalid = 0;
      req_tuser = 0;
      req_tdata = '0;
      rsp_tready = 0;
      csr_we = 0;
      csr_wdata = '0;
      m_idle = IDLE_RESET;
      foreach (m_status[j]) m_status[j] = ST_EMPTY;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      rows = '{
         '{0, 64'd0, 64'd0, 64'd0, 1, 1, V_UNKNOWN},
         '{1, 64'd0, 64'd0, 64'd0, 1, 1, V_NEW},
         '{1, 64'd0, 64'd0, 64'd1, 1, 0, V_REPLAY},
         '{0, 64'd0, 64'd5, 64'd2, 1, 1, V_ADV},
         '{1, 64'd0, 64'd5, 64'd3, 1, 1, V_ADV},
         '{1, 64'd0, 64'd3, 64'd4, 1, 1, V_FRESH},
         '{0, 64'd0, 64'd3, 64'd5, 1, 0, V_REPLAY},
         '{1, 64'd0, 64'd3, 64'd5, 1, 0, V_REPLAY},
         '{1, 64'd0, 64'd16389, 64'd6, 1, 1, V_ADV},
         '{0, 64'd0, 64'd5, 64'd7, 1, 0, V_OLD},
         '{1, 64'd0, 64'd5, 64'd7, 1, 0, V_OLD},
         '{0, 64'd0, 64'd6, 64'd8, 1, 1, V_FRESH},
         '{1, 64'd0, 64'd16500, 64'd9, 0, 0, V_NEW},
         '{1, ones, ones, 64'd10, 0, 0, V_NEW},
         '{1, ones, ones, 64'd11, 0, 0, V_NEW},
         '{1, ones, ones - 64'd1, 64'd12, 0, 0, V_NEW},
         '{0, ones, 64'd0, 64'd13, 0, 0, V_NEW},
         '{1, ones, 64'd0, ones, 0, 0, V_NEW},
         '{1, 64'h5555_5555_5555_5555, 64'h8000_0000_0000_0000, ones, 0, 0, V_NEW},
         '{1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 0, 0, V_NEW},
         '{0, 64'hAAAA_AAAA_AAAA_AAAA, ones, ones, 0, 0, V_NEW}
      };
      foreach (rows[j]) begin
         te.acc = rows[j].acc;
         te.ver = rows[j].ver;
         send_item(rows[j].commit, rows[j].sid, rows[j].cnt, rows[j].now,
                   rows[j].typed, te);
      end

      for (i = 0; i < POOL; i++) begin
         pool_sid[i] = {$urandom, $urandom};
         pool_hi[i]  = {$urandom, $urandom};
      end
      pool_sid[0] = '0;
      pool_sid[1] = ones;
      clk_now = 64'd1000;

      for (ph = 0; ph < 4; ph++) begin
         drain_and_write(limits[ph]);
         calm = (ph == 2);
         for (t = 0; t < 210; t++) begin
            k = (ph == 0) ? $urandom_range(0, POOL - 1) : $urandom_range(0, 39);
            sid = pool_sid[k];
            r = $urandom_range(0, 99);
            if (r < 40)      cnt = pool_hi[k] + $urandom_range(1, 50);
            else if (r < 60) cnt = pool_hi[k] - $urandom_range(0, 200);
            else if (r < 68) cnt = pool_hi[k] + $urandom_range(16384, 40000);
            else if (r < 78) cnt = pool_hi[k] - $urandom_range(16384, 20000);
            else if (r < 84) cnt = {$urandom, $urandom};
            else             cnt = pool_hi[k];
            commit = ($urandom_range(0, 99) < 70);
            if ($urandom_range(0, 99) < 5) sid = {$urandom, $urandom};
            r = $urandom_range(0, 99);
            if (r < 4)       clk_now = clk_now + $urandom_range(1000, 100000);
            else if (r < 6)  clk_now = {$urandom, $urandom};
            else             clk_now = clk_now + $urandom_range(0, 300);
            if (commit && sid == pool_sid[k] && cnt > pool_hi[k]) pool_hi[k] = cnt;
            send_item(commit, sid, cnt, clk_now, 0, te);
            if (t == 100 && ph == 1) begin
               req_tvalid <= 0;
               while (verdicts_due.size() != 0) @(posedge clock);
            end
         end
      end

      req_tvalid <= 0;
      calm = 0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("tb: %0d transactions sent, %0d responses checked under four idle limits",
               n_sent, n_seen);
      $display("tb: verdicts new %0d adv %0d fresh %0d replay %0d old %0d full %0d unknown %0d",
               vcount[0], vcount[1], vcount[2], vcount[3], vcount[4], vcount[5], vcount[6]);
      if (errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/psrw_pkg.sv
hw/rtl/psrw_modred.sv
hw/rtl/psrw_ctrl.sv
hw/rtl/psrw_datapath.sv
hw/rtl/per_session_replay_window.sv
hw/rtl/psrw_checker.sv
dv/tb.sv
